// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/isle_pkg.sv
// ----------------------------------------------------------------------------
// isle_pkg
// Types and constants shared by the indexed shift list engine.
// ----------------------------------------------------------------------------
package isle_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 7;
    localparam int CMD_W        = 3;
    localparam int IDX_OUT_W    = 6;
    localparam int CNT_OUT_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT     = 3'd0,
        CMD_REMOVE_AT  = 3'd1,
        CMD_REMOVE_ONE = 3'd2,
        CMD_REMOVE_ALL = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_READ       = 3'd5,
        CMD_ERASE      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_KEEP = 2'd1,
        OP_DROP = 2'd2,
        OP_INS  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic signed [VAL_W-1:0] head;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// File: sv/isle_cmd_if.sv
// ----------------------------------------------------------------------------
// isle_cmd_if
// Command channel of the indexed shift list engine.
// ----------------------------------------------------------------------------
interface isle_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [6:0]         position;
    logic [6:0]         range_end;
    logic signed [31:0] operand_value;

    modport source (output valid, command, position, range_end, operand_value, input ready);
    modport sink   (input valid, command, position, range_end, operand_value, output ready);
endinterface

// File: sv/isle_res_if.sv
// ----------------------------------------------------------------------------
// isle_res_if
// Result channel of the indexed shift list engine.
// ----------------------------------------------------------------------------
interface isle_res_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [5:0]         found_index;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               is_empty;

    modport source (output valid, ok, found_index, read_value, entry_count, min_value,
                    max_value, is_empty, input ready);
    modport sink   (input valid, ok, found_index, read_value, entry_count, min_value,
                    max_value, is_empty, output ready);
endinterface

// File: sv/isle_cell.sv
// ----------------------------------------------------------------------------
// isle_cell
// One storage cell of the list chain; moves its word toward the head, or takes the head word or an inserted word.
// ----------------------------------------------------------------------------
module isle_cell
    import isle_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic                    i_clk,
    input  t_cell_ctrl              i_ctrl,
    input  logic [CNT_W-1:0]        i_count,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_value
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;
    logic                    below_tail;
    logic                    at_tail;
    logic                    at_free;

    assign below_tail = {1'b0, i_count} > (CNT_W+1)'(INDEX + 1);
    assign at_tail    = i_count == CNT_W'(INDEX + 1);
    assign at_free    = i_count == CNT_W'(INDEX);

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_KEEP: begin
                if (below_tail) begin
                    n_value = i_right;
                end else if (at_tail) begin
                    n_value = i_ctrl.head;
                end
            end
            OP_DROP: begin
                if (below_tail) begin
                    n_value = i_right;
                end
            end
            OP_INS: begin
                if (at_free) begin
                    n_value = i_ctrl.value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: sv/indexed_shift_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_shift_list_engine
// Ordered list of signed words held in a chain of cells.
// ----------------------------------------------------------------------------
// One command is taken at a time. The list rotates through the head cell once
// per command, one entry per cycle except while an insert is written; entries
// are dropped or inserted during that rotation, and the minimum, maximum,
// search and read results are gathered from the head (and the inserted word)
// as it passes.
module indexed_shift_list_engine
    import isle_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    isle_cmd_if.sink     i_cmd,
    isle_res_if.source   o_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_n0;
    logic [CNT_W-1:0]        r_j, n_j;
    t_cmd                    r_cmd;
    logic [POS_W-1:0]        r_pos, r_end;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_v;
    logic                    r_ins_done, n_ins_done;
    logic                    r_found, n_found;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic signed [VAL_W-1:0] r_rd, n_rd;
    logic                    r_has, n_has;
    logic signed [VAL_W-1:0] r_min, n_min, r_max, n_max;
    logic                    r_out_valid;

    logic signed [VAL_W-1:0] cell_val [CAPACITY];
    t_cell_ctrl              ctrl;
    logic signed [VAL_W-1:0] head;
    logic [CMP_W-1:0]        pos_x, end_x, j_x, cnt_x;
    logic                    start_v;
    logic                    step_ins, step_head, drop, match, take;
    logic signed [VAL_W-1:0] sample;
    logic                    fin_ok;
    logic                    accept;

    assign head   = cell_val[0];
    assign accept = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        logic [CMP_W-1:0] ip, ie;
        ip = CMP_W'(i_cmd.position);
        ie = CMP_W'(i_cmd.range_end);
        cnt_x = CMP_W'(r_count);
        case (t_cmd'(i_cmd.command))
            CMD_INSERT:     start_v = (ip <= cnt_x) && (cnt_x < CMP_W'(CAPACITY));
            CMD_REMOVE_AT:  start_v = ip < cnt_x;
            CMD_READ:       start_v = ip < cnt_x;
            CMD_ERASE:      start_v = (ip <= ie) && (ie <= cnt_x);
            CMD_REMOVE_ONE: start_v = 1'b1;
            CMD_REMOVE_ALL: start_v = 1'b1;
            CMD_FIND:       start_v = 1'b1;
            default:        start_v = 1'b0;
        endcase
    end

    assign pos_x = CMP_W'(r_pos);
    assign end_x = CMP_W'(r_end);
    assign j_x   = CMP_W'(r_j);
    assign match = head == r_val;

    always_comb begin
        step_ins  = (r_state == S_RUN) && (r_cmd == CMD_INSERT) && r_v && !r_ins_done
                    && (j_x == pos_x);
        step_head = (r_state == S_RUN) && !step_ins && (r_j < r_n0);
        drop      = 1'b0;
        if (step_head && r_v) begin
            case (r_cmd)
                CMD_REMOVE_AT:  drop = j_x == pos_x;
                CMD_REMOVE_ONE: drop = !r_found && match;
                CMD_REMOVE_ALL: drop = match;
                CMD_ERASE:      drop = (j_x >= pos_x) && (j_x < end_x);
                default:        drop = 1'b0;
            endcase
        end
        take   = step_ins || (step_head && !drop);
        sample = step_ins ? r_val : head;
    end

    always_comb begin
        ctrl.head  = head;
        ctrl.value = r_val;
        if (step_ins) begin
            ctrl.op = OP_INS;
        end else if (drop) begin
            ctrl.op = OP_DROP;
        end else if (step_head) begin
            ctrl.op = OP_KEEP;
        end else begin
            ctrl.op = OP_HOLD;
        end
    end

    generate
        for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
            logic signed [VAL_W-1:0] right;
            if (k == CAPACITY - 1) begin : g_last
                assign right = '0;
            end else begin : g_mid
                assign right = cell_val[k+1];
            end
            isle_cell #(
                .CNT_W (CNT_W),
                .INDEX (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_count (r_count),
                .i_right (right),
                .o_value (cell_val[k])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_j        = r_j;
        n_ins_done = r_ins_done;
        n_found    = r_found;
        n_idx      = r_idx;
        n_rd       = r_rd;
        n_has      = r_has;
        n_min      = r_min;
        n_max      = r_max;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_RUN;
                    n_j        = '0;
                    n_ins_done = 1'b0;
                    n_found    = 1'b0;
                    n_idx      = '0;
                    n_rd       = '0;
                    n_has      = 1'b0;
                end
            end
            S_RUN: begin
                if (step_ins) begin
                    n_ins_done = 1'b1;
                    n_count    = r_count + 1'b1;
                end else if (step_head) begin
                    n_j = r_j + 1'b1;
                    if (drop) begin
                        n_count = r_count - 1'b1;
                    end
                    if (match && !r_found
                        && (r_cmd == CMD_REMOVE_ONE || r_cmd == CMD_FIND)) begin
                        n_found = 1'b1;
                        n_idx   = r_j;
                    end
                    if (r_cmd == CMD_READ && r_v && j_x == pos_x) begin
                        n_rd = head;
                    end
                end else begin
                    n_state = S_DONE;
                end
                if (take) begin
                    n_has = 1'b1;
                    if (!r_has || sample < r_min) begin
                        n_min = sample;
                    end
                    if (!r_has || sample > r_max) begin
                        n_max = sample;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_cmd)
            CMD_REMOVE_ONE: fin_ok = r_found;
            CMD_FIND:       fin_ok = r_found;
            default:        fin_ok = r_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_ins_done <= n_ins_done;
        r_found    <= n_found;
        r_idx      <= n_idx;
        r_rd       <= n_rd;
        r_has      <= n_has;
        r_min      <= n_min;
        r_max      <= n_max;
        if (accept) begin
            r_cmd <= t_cmd'(i_cmd.command);
            r_pos <= i_cmd.position;
            r_end <= i_cmd.range_end;
            r_val <= i_cmd.operand_value;
            r_v   <= start_v;
            r_n0  <= r_count;
        end
        if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
            o_res.ok          <= fin_ok;
            o_res.found_index <= (r_cmd == CMD_FIND && r_found)
                                 ? IDX_OUT_W'(CMP_W'(r_idx)) : '0;
            o_res.read_value  <= r_rd;
            o_res.entry_count <= CNT_OUT_W'(CMP_W'(r_count));
            o_res.min_value   <= (r_count != '0) ? r_min : '0;
            o_res.max_value   <= (r_count != '0) ? r_max : '0;
            o_res.is_empty    <= r_count == '0;
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

// File: sv/isle_checker.sv
// ----------------------------------------------------------------------------
// isle_checker
// Port-level checks on the result channel of the list engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isle_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [6:0]         i_count,
    input logic               i_empty,
    input logic signed [31:0] i_min,
    input logic signed [31:0] i_max
);

    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_count))
    `ASSERT_IMPLY(a_empty_count, i_clk, i_rst_n, i_valid, i_empty == (i_count == 7'd0))
    `ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, i_valid && i_empty, i_min == 0 && i_max == 0)
    `ASSERT_IMPLY(a_min_le_max, i_clk, i_rst_n, i_valid && !i_empty, i_min <= i_max)

endmodule

bind indexed_shift_list_engine isle_port_checks u_isle_port_checks (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_count (o_res.entry_count),
    .i_empty (o_res.is_empty),
    .i_min   (o_res.min_value),
    .i_max   (o_res.max_value)
);
